/* rtl/core/bbrs_pkg.sv */
// Shared types and constants for the budgeted best-first route search core.
// Used by bbrs_edge_store, bbrs_frontier and the top level.
package bbrs_pkg;

  localparam int NODE_W     = 6;
  localparam int NODE_COUNT = 64;
  localparam int COST_W     = 16;
  localparam int TCOST_W    = 19;
  localparam int DEG        = 8;
  localparam int SLOT_W     = $clog2(DEG);
  localparam int CNT_W      = $clog2(DEG + 1);
  localparam int ESLOTS     = NODE_COUNT * DEG;
  localparam int ROUTE_MAX  = 7;
  localparam int LEN_W      = 3;
  localparam int FDEPTH     = 48;
  localparam int FIDX_W     = $clog2(FDEPTH + 1);
  localparam int SEQ_W      = 6;
  localparam int ROUND_W    = 3;

  localparam logic [ROUND_W-1:0] MAX_ROUNDS = 3'd5;
  localparam logic [TCOST_W-1:0] TCOST_MAX  = 19'h7FFFF;
  localparam logic [TCOST_W-1:0] CEIL_RST   = 19'd99999;
  localparam logic [2:0]         MAXEXP_RST = 3'd5;

  localparam logic CFG_MAX_EXP = 1'b0;
  localparam logic CFG_CEILING = 1'b1;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_ROUTE   = 3'd0,
    ST_SAME    = 3'd1,
    ST_NOROUTE = 3'd2,
    ST_ADDED   = 3'd3,
    ST_UPDATED = 3'd4,
    ST_FULL    = 3'd5,
    ST_CLEARED = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_ADD_RD, S_ADD_CHK, S_GRD, S_GCHK,
    S_APPEND, S_SCAN0, S_SCAN, S_POP, S_EMIT
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] dst;
    logic [COST_W-1:0] cost;
  } edge_t;

  typedef struct packed {
    logic [SEQ_W-1:0]                    seq;
    logic [ROUTE_MAX-1:0][NODE_W-1:0]    route;
    logic [LEN_W-1:0]                    len;
    logic [TCOST_W-1:0]                  cost;
  } fent_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clr;
    logic              inc;
    logic [NODE_W-1:0] node;
    logic [SLOT_W-1:0] slot;
    edge_t             wdata;
  } edge_req_t;

  typedef struct packed {
    logic              rd_en;
    logic [FIDX_W-1:0] rd_idx;
    logic              wr_en;
    fent_t             wdata;
    logic              clr_all;
    logic              kill;
    logic [FIDX_W-1:0] kill_idx;
  } fr_req_t;

endpackage

/* rtl/core/bbrs_edge_store.sv */
// Edge table: one synchronous RAM row of DEG slots per origin node,
// plus a per-node fill count. Depends on bbrs_pkg.
module bbrs_edge_store
  import bbrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  edge_req_t        req_i,
  output edge_t            rd_data_o,
  output logic [CNT_W-1:0] cnt_o
);

  edge_t            mem_q [ESLOTS];
  edge_t            rd_q;
  logic [CNT_W-1:0] cnt_q [NODE_COUNT];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[{req_i.node, req_i.slot}] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[{req_i.node, req_i.slot}];
    end
  end

  // Slots fill in order and free only on clear, so the count marks validity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NODE_COUNT; n++) cnt_q[n] <= '0;
    end else if (req_i.clr) begin
      for (int n = 0; n < NODE_COUNT; n++) cnt_q[n] <= '0;
    end else if (req_i.inc) begin
      cnt_q[req_i.node] <= cnt_q[req_i.node] + 1'b1;
    end
  end

  assign rd_data_o = rd_q;
  assign cnt_o     = cnt_q[req_i.node];

endmodule

/* rtl/core/bbrs_frontier.sv */
// Frontier store: synchronous RAM of entries, valid flags, live count and
// lowest-free-slot allocation. Depends on bbrs_pkg.
module bbrs_frontier
  import bbrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fr_req_t           req_i,
  output fent_t             rd_data_o,
  output logic [FDEPTH-1:0] valid_o,
  output logic              full_o
);

  fent_t             mem_q [FDEPTH];
  fent_t             rd_q;
  logic [FDEPTH-1:0] valid_q;
  logic [FIDX_W-1:0] live_q;
  logic [FIDX_W-1:0] free_idx;

  always_comb begin
    free_idx = '0;
    for (int i = FDEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = FIDX_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[free_idx] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      live_q  <= '0;
    end else if (req_i.clr_all) begin
      valid_q <= '0;
      live_q  <= '0;
    end else if (req_i.wr_en) begin
      valid_q[free_idx] <= 1'b1;
      live_q            <= live_q + 1'b1;
    end else if (req_i.kill) begin
      valid_q[req_i.kill_idx] <= 1'b0;
      live_q                  <= live_q - 1'b1;
    end
  end

  assign rd_data_o = rd_q;
  assign valid_o   = valid_q;
  assign full_o    = (live_q == FIDX_W'(FDEPTH));

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q == FIDX_W'($countones(valid_q)))
    else $error("frontier live count mismatch");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en && !req_i.clr_all |-> !full_o)
    else $error("frontier write while full");

endmodule

/* rtl/core/budgeted_best_first_route_search_core.sv */
// Budgeted best-first route search: control sequencer, config registers and
// output register. Depends on bbrs_pkg, bbrs_edge_store, bbrs_frontier.
//
// Usage:
//   s_axis carries requests: tuser = req_type, tdata = src_node, dst_node,
//   edge_cost. m_axis returns results: tuser = status, tdata = total_cost,
//   route_node, tlast = last_item. cfg_we_i/cfg_idx_i/cfg_data_i write the
//   round limit (index 0) and the cost ceiling (index 1) while idle.
//   One request is handled at a time; tready is high only when idle.
//   Clear goes straight to the response; add/update reads each probed slot
//   in the edge RAM and then checks it. A query gathers each node by reading
//   every stored edge and appending its children, and each round scans all 48
//   frontier RAM entries (one read per cycle); up to six rounds are run.
//   Route results then stream one per cycle while m_axis_tready is high.
//   The output register holds a result while m_axis_tready is low; the core
//   waits before producing the next result, and a new request can be taken
//   while the last result still waits.
//   Reset clears the edge fill counts, the frontier flags and the config
//   registers (limit 5, ceiling 99999); no clearing pass is needed.
module budgeted_best_first_route_search_core
  import bbrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // src_node[5:0], dst_node[11:6], edge_cost[27:12]
  input  logic [1:0]   s_axis_tuser,  // req_type[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // total_cost[18:0], route_node[24:19]
  output logic [2:0]   m_axis_tuser,  // status[2:0]
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [18:0]  cfg_data_i
);

  state_e state_q, state_d;
  logic [NODE_W-1:0]  src_q, src_d, dst_q, dst_d;
  logic [COST_W-1:0]  cost_q, cost_d;
  logic [CNT_W-1:0]   k_q, k_d, m_q, m_d, j_q, j_d, pos;
  edge_t              list_q [DEG];
  edge_t              list_d [DEG];
  fent_t              pop_q, pop_d, app_ent;
  logic               init_q, init_d, found_q, found_d, pend_q, pend_d;
  logic [ROUND_W-1:0] round_q, round_d, limit;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic [FIDX_W-1:0]  scan_q, scan_d, pidx_q, pidx_d, bidx_q, bidx_d;
  status_e            rstat_q, rstat_d;
  logic [NODE_W-1:0]  rnode_q, rnode_d, lastn;
  logic [LEN_W-1:0]   emit_q, emit_d;
  logic [2:0]         maxexp_q;
  logic [TCOST_W-1:0] ceil_q, best_cost;
  logic [TCOST_W:0]   sum;

  logic               out_ld, out_last, out_free;
  status_e            out_stat;
  logic [TCOST_W-1:0] out_cost;
  logic [NODE_W-1:0]  out_node;
  logic               m_valid_q, m_last_q;
  logic [31:0]        m_data_q;
  logic [2:0]         m_user_q;

  edge_req_t          ereq;
  edge_t              erd;
  logic [CNT_W-1:0]   ecnt;
  fr_req_t            freq;
  fent_t              frd;
  logic [FDEPTH-1:0]  fvalid;
  logic               ffull;
  edge_t              child;

  bbrs_edge_store u_edges (
    .clk_i, .rst_ni, .req_i(ereq), .rd_data_o(erd), .cnt_o(ecnt)
  );

  bbrs_frontier u_front (
    .clk_i, .rst_ni, .req_i(freq), .rd_data_o(frd), .valid_o(fvalid), .full_o(ffull)
  );

  assign limit     = (maxexp_q > MAX_ROUNDS) ? MAX_ROUNDS : maxexp_q;
  assign lastn     = pop_q.route[LEN_W'(pop_q.len - 1'b1)];
  assign out_free  = !m_valid_q || m_axis_tready;
  assign child     = list_q[j_q[SLOT_W-1:0]];
  assign best_cost = found_q ? pop_q.cost : ceil_q;

  always_comb begin
    pos = '0;
    for (int p = 0; p < DEG; p++) begin
      if (CNT_W'(p) < m_q && list_q[p].dst <= erd.dst) pos = pos + 1'b1;
    end
  end

  always_comb begin
    sum     = {1'b0, pop_q.cost} + (TCOST_W + 1)'(child.cost);
    app_ent = pop_q;
    app_ent.cost = sum[TCOST_W] ? TCOST_MAX : sum[TCOST_W-1:0];
    app_ent.route[pop_q.len] = child.dst;
    app_ent.len = pop_q.len + 1'b1;
    app_ent.seq = seq_q;
  end

  always_comb begin
    state_d = state_q;
    src_d = src_q; dst_d = dst_q; cost_d = cost_q;
    k_d = k_q; m_d = m_q; j_d = j_q;
    for (int p = 0; p < DEG; p++) list_d[p] = list_q[p];
    pop_d = pop_q; init_d = init_q; found_d = found_q; pend_d = pend_q;
    round_d = round_q; seq_d = seq_q; scan_d = scan_q; pidx_d = pidx_q;
    bidx_d = bidx_q; rstat_d = rstat_q; rnode_d = rnode_q; emit_d = emit_q;
    out_ld = 1'b0; out_stat = ST_ROUTE; out_cost = '0; out_node = '0; out_last = 1'b1;
    s_axis_tready = 1'b0;
    ereq = '0;
    ereq.node = (state_q == S_GRD || state_q == S_GCHK) ? lastn : src_q;
    ereq.wdata = '{dst: dst_q, cost: cost_q};
    freq = '0;
    freq.wdata = app_ent;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          src_d   = s_axis_tdata[5:0];
          dst_d   = s_axis_tdata[11:6];
          cost_d  = s_axis_tdata[27:12];
          rnode_d = '0;
          k_d     = '0;
          m_d     = '0;
          case (s_axis_tuser)
            REQ_CLEAR: begin
              ereq.clr = 1'b1;
              rstat_d  = ST_CLEARED;
              state_d  = S_RESP;
            end
            REQ_ADD: state_d = S_ADD_RD;
            REQ_QUERY: begin
              if (s_axis_tdata[5:0] == s_axis_tdata[11:6]) begin
                rstat_d = ST_SAME;
                rnode_d = s_axis_tdata[5:0];
                state_d = S_RESP;
              end else begin
                freq.clr_all = 1'b1;
                seq_d        = '0;
                init_d       = 1'b1;
                pop_d        = '0;
                pop_d.len    = LEN_W'(1);
                pop_d.route[0] = s_axis_tdata[5:0];
                state_d      = S_GRD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_ld   = 1'b1;
          out_stat = rstat_q;
          out_node = rnode_q;
          state_d  = S_IDLE;
        end
      end
      S_ADD_RD: begin
        if (k_q == ecnt) begin
          if (ecnt == CNT_W'(DEG)) begin
            rstat_d = ST_FULL;
          end else begin
            ereq.wr_en = 1'b1;
            ereq.inc   = 1'b1;
            ereq.slot  = ecnt[SLOT_W-1:0];
            rstat_d    = ST_ADDED;
          end
          state_d = S_RESP;
        end else begin
          ereq.rd_en = 1'b1;
          ereq.slot  = k_q[SLOT_W-1:0];
          state_d    = S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        ereq.slot = k_q[SLOT_W-1:0];
        if (erd.dst == dst_q) begin
          ereq.wr_en = 1'b1;
          rstat_d    = ST_UPDATED;
          state_d    = S_RESP;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_ADD_RD;
        end
      end
      S_GRD: begin
        if (k_q == ecnt) begin
          j_d     = '0;
          state_d = S_APPEND;
        end else begin
          ereq.rd_en = 1'b1;
          ereq.slot  = k_q[SLOT_W-1:0];
          state_d    = S_GCHK;
        end
      end
      S_GCHK: begin
        if (erd.cost != '0) begin
          for (int p = 0; p < DEG; p++) begin
            if (CNT_W'(p) == pos) list_d[p] = erd;
            else if (CNT_W'(p) > pos) list_d[p] = list_q[(p == 0) ? 0 : p - 1];
          end
          m_d = m_q + 1'b1;
        end
        k_d     = k_q + 1'b1;
        state_d = S_GRD;
      end
      S_APPEND: begin
        if (j_q == m_q) begin
          round_d = init_q ? '0 : round_q + 1'b1;
          init_d  = 1'b0;
          state_d = S_SCAN0;
        end else begin
          if (!((!init_q && child.dst == src_q) || ffull)) begin
            freq.wr_en = 1'b1;
            seq_d      = seq_q + 1'b1;
          end
          j_d = j_q + 1'b1;
        end
      end
      S_SCAN0: begin
        rnode_d = '0;
        if (round_q > limit) begin
          rstat_d = ST_NOROUTE;
          state_d = S_RESP;
        end else begin
          scan_d  = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q != FIDX_W'(FDEPTH)) begin
          freq.rd_en  = 1'b1;
          freq.rd_idx = scan_q;
          scan_d      = scan_q + 1'b1;
          pend_d      = 1'b1;
          pidx_d      = scan_q;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) state_d = S_POP;
        end
        if (pend_q && fvalid[pidx_q] && (frd.cost < best_cost ||
            (found_q && frd.cost == pop_q.cost && frd.seq < pop_q.seq))) begin
          pop_d   = frd;
          bidx_d  = pidx_q;
          found_d = 1'b1;
        end
      end
      S_POP: begin
        if (!found_q) begin
          rstat_d = ST_NOROUTE;
          state_d = S_RESP;
        end else if (lastn == dst_q) begin
          emit_d  = '0;
          state_d = S_EMIT;
        end else begin
          freq.kill     = 1'b1;
          freq.kill_idx = bidx_q;
          if (pop_q.len < LEN_W'(ROUTE_MAX)) begin
            k_d     = '0;
            m_d     = '0;
            state_d = S_GRD;
          end else begin
            round_d = round_q + 1'b1;
            state_d = S_SCAN0;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_ld   = 1'b1;
          out_stat = ST_ROUTE;
          out_cost = pop_q.cost;
          out_node = pop_q.route[emit_q];
          out_last = (emit_q == LEN_W'(pop_q.len - 1'b1));
          emit_d   = emit_q + 1'b1;
          if (out_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      init_q   <= 1'b0;
      found_q  <= 1'b0;
      pend_q   <= 1'b0;
      round_q  <= '0;
      m_valid_q <= 1'b0;
      maxexp_q <= MAXEXP_RST;
      ceil_q   <= CEIL_RST;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      found_q <= found_d;
      pend_q  <= pend_d;
      round_q <= round_d;
      if (out_ld) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_EXP: maxexp_q <= cfg_data_i[2:0];
          CFG_CEILING: ceil_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d; dst_q <= dst_d; cost_q <= cost_d;
    k_q <= k_d; m_q <= m_d; j_q <= j_d;
    for (int p = 0; p < DEG; p++) list_q[p] <= list_d[p];
    pop_q <= pop_d; seq_q <= seq_d; scan_q <= scan_d; pidx_q <= pidx_d;
    bidx_q <= bidx_d; rstat_q <= rstat_d; rnode_q <= rnode_d; emit_q <= emit_d;
    if (out_ld) begin
      m_data_q <= {7'b0, out_node, out_cost};
      m_user_q <= out_stat;
      m_last_q <= out_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_ROUTE |-> m_axis_tlast)
    else $error("non-route result without last");

  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> found_q)
    else $error("route emitted without a popped entry");

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> round_q <= MAX_ROUNDS)
    else $error("round count beyond budget");

endmodule
